// ===== rtl/pa_pkg.sv =====
`timescale 1ns / 1ps
package pa_pkg;

    // Slot store geometry
    localparam int SLOT_DEPTH = 64;
    localparam int SLOT_AW    = 6;
    localparam int FILL_W     = 7;
    localparam int FIELD_HW   = 16;

    // Event kinds
    localparam logic [1:0] FN_BEGIN  = 2'd0;
    localparam logic [1:0] FN_VERTEX = 2'd1;
    localparam logic [1:0] FN_END    = 2'd2;

    // Primitive types, standard GL order
    localparam logic [3:0] PT_POINTS     = 4'd0;
    localparam logic [3:0] PT_LINES      = 4'd1;
    localparam logic [3:0] PT_LINE_LOOP  = 4'd2;
    localparam logic [3:0] PT_LINE_STRIP = 4'd3;
    localparam logic [3:0] PT_TRIS       = 4'd4;
    localparam logic [3:0] PT_TRI_STRIP  = 4'd5;
    localparam logic [3:0] PT_TRI_FAN    = 4'd6;
    localparam logic [3:0] PT_QUADS      = 4'd7;
    localparam logic [3:0] PT_QUAD_STRIP = 4'd8;
    localparam logic [3:0] PT_POLYGON    = 4'd9;

    // Result kinds
    localparam logic [1:0] PK_NONE  = 2'd0;
    localparam logic [1:0] PK_POINT = 2'd1;
    localparam logic [1:0] PK_LINE  = 2'd2;
    localparam logic [1:0] PK_TRI   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_SEQUENCE = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [3:0]          prim_type;
        logic [FIELD_HW-1:0] vertex_handle;
        logic                edge_in;
    } t_in;

    typedef struct packed {
        logic [1:0]          prim_kind;
        logic [FIELD_HW-1:0] handle_a;
        logic [FIELD_HW-1:0] handle_b;
        logic [FIELD_HW-1:0] handle_c;
        logic                edge_a;
        logic                edge_b;
        logic                edge_c;
        logic [1:0]          error;
        logic                last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SECOND,
        ST_POLY_PRIME,
        ST_POLY_RUN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take_in;
        logic emit_second;
        logic poly_prime;
        logic poly_step;
    } t_dp_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic two_results;
        logic poly_end;
        logic walk_last;
    } t_dp_status;

endpackage

// ===== rtl/primitive_assembler.sv =====
`timescale 1ns / 1ps
// Channel   Valid        Ready        Payload
// input     i_in_valid   o_in_ready   i_in_data  (pa_pkg::t_in)
// output    o_out_valid  i_out_ready  o_out_data (pa_pkg::t_out)
//
// One event per cycle while the output register drains and no second result or
// polygon walk is pending; an event's result is registered on its transaction.
// Quads and quad strip emit two triangles, the second from a pending register.
// A polygon end walks the slot RAM through its single read port: a priming read,
// then one triangle per cycle while the output drains, fill-2 triangles in all.
// Synchronous active-low reset clears the control state; slots need no clear.
// A stalled output register holds the block: no input is taken until it drains.
module primitive_assembler #(
    parameter int MAX_POLY_VERTICES = 64,
    parameter int HANDLE_BITS       = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  pa_pkg::t_in  i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output pa_pkg::t_out o_out_data
);
    import pa_pkg::*;

    t_dp_ctrl   ctrl;
    t_dp_status stat;

    pa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (o_in_ready)
    );

    pa_dp #(
        .MAX_POLY_VERTICES (MAX_POLY_VERTICES),
        .HANDLE_BITS       (HANDLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_out_ready (i_out_ready),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );
endmodule

// ===== rtl/pa_ram.sv =====
`timescale 1ns / 1ps
module pa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pa_ctrl.sv =====
`timescale 1ns / 1ps
module pa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pa_pkg::t_dp_status  i_stat,
    output pa_pkg::t_dp_ctrl    o_ctrl,
    output logic                o_in_ready
);
    import pa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_ready;

    assign in_ready   = (r_state == ST_IDLE) && i_stat.out_free;
    assign o_in_ready = in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && in_ready) begin
                    if (i_stat.two_results) begin
                        n_state = ST_SECOND;
                    end else if (i_stat.poly_end) begin
                        n_state = ST_POLY_PRIME;
                    end
                end
            end
            ST_SECOND: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POLY_PRIME: begin
                n_state = ST_POLY_RUN;
            end
            ST_POLY_RUN: begin
                if (i_stat.out_free && i_stat.walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_IDLE:       o_ctrl.take_in     = i_in_valid && in_ready;
            ST_SECOND:     o_ctrl.emit_second = i_stat.out_free;
            ST_POLY_PRIME: o_ctrl.poly_prime  = 1'b1;
            ST_POLY_RUN:   o_ctrl.poly_step   = i_stat.out_free;
            default:       o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/pa_dp.sv =====
`timescale 1ns / 1ps
module pa_dp #(
    parameter int MAX_POLY_VERTICES = 64,
    parameter int HANDLE_BITS       = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pa_pkg::t_in        i_in,
    input  logic               i_out_ready,
    input  pa_pkg::t_dp_ctrl   i_ctrl,
    output pa_pkg::t_dp_status o_stat,
    output logic               o_out_valid,
    output pa_pkg::t_out       o_out
);
    import pa_pkg::*;

    localparam int HW = (HANDLE_BITS < FIELD_HW) ? HANDLE_BITS : FIELD_HW;
    localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_POLY_VERTICES);

    // Primitive state
    logic              r_inside, n_inside;
    logic [3:0]        r_type, n_type;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [1:0]        r_cnt, n_cnt;
    logic              r_par, n_par;
    logic [HW-1:0]     r_sh [4];
    logic [HW-1:0]     n_sh [4];
    logic [3:0]        r_se, n_se;

    // Output and walk registers
    logic               r_ovalid, n_ovalid;
    t_out               r_out, n_out;
    t_out               r_pend, n_pend;
    logic [HW:0]        r_hi, n_hi;
    logic [SLOT_AW-1:0] r_ptr, n_ptr;

    // Decode results
    logic          has1, two, walk, we;
    t_out          res1, res2;
    logic [HW-1:0] s_sh [4];
    logic [3:0]    s_se;
    logic [HW-1:0] v_h;
    logic [1:0]    fidx, cnt_nx;
    logic          three_nx, out_free;

    logic [SLOT_AW-1:0] raddr;
    logic [HW:0]        rdata;

    function automatic t_out mk(input logic [1:0] kind,
                                input logic [HW-1:0] ha, input logic [HW-1:0] hb,
                                input logic [HW-1:0] hc, input logic ea,
                                input logic eb, input logic ec,
                                input logic [1:0] err, input logic lst);
        t_out r;
        r.prim_kind = kind;
        r.handle_a  = FIELD_HW'(ha);
        r.handle_b  = FIELD_HW'(hb);
        r.handle_c  = FIELD_HW'(hc);
        r.edge_a    = ea;
        r.edge_b    = eb;
        r.edge_c    = ec;
        r.error     = err;
        r.last      = lst;
        return r;
    endfunction

    assign out_free = !r_ovalid || i_out_ready;
    assign v_h      = i_in.vertex_handle[HW-1:0];
    assign fidx     = r_fill[1:0];
    assign cnt_nx   = (r_cnt == 2'd3) ? 2'd3 : r_cnt + 2'd1;
    assign three_nx = (cnt_nx == 2'd3);

    // Slot view after storing the incoming vertex
    always_comb begin
        s_sh = r_sh;
        s_se = r_se;
        s_sh[fidx] = v_h;
        s_se[fidx] = i_in.edge_in;
    end

    // Decode one event against the primitive state
    always_comb begin
        n_inside = r_inside;
        n_type   = r_type;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_par    = r_par;
        n_sh     = r_sh;
        n_se     = r_se;
        has1     = 1'b0;
        two      = 1'b0;
        walk     = 1'b0;
        we       = 1'b0;
        res1     = mk(PK_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0, ERR_SEQUENCE, 1'b1);
        res2     = mk(PK_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0, ERR_OK, 1'b1);
        unique case (i_in.func)
            FN_BEGIN: begin
                if (r_inside) begin
                    has1 = 1'b1;
                end else begin
                    n_inside = 1'b1;
                    n_type   = i_in.prim_type;
                    n_fill   = '0;
                    n_cnt    = '0;
                    n_par    = 1'b0;
                end
            end
            FN_VERTEX: begin
                if (!r_inside) begin
                    has1 = 1'b1;
                end else begin
                    n_cnt = cnt_nx;
                    n_par = ~r_par;
                    unique case (r_type)
                        PT_POINTS: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            n_fill = '0;
                            has1 = 1'b1;
                            res1 = mk(PK_POINT, v_h, '0, '0, i_in.edge_in, 1'b0, 1'b0,
                                      ERR_OK, 1'b1);
                        end
                        PT_LINES: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            if (r_fill == FILL_W'(1)) begin
                                has1 = 1'b1;
                                res1 = mk(PK_LINE, s_sh[0], s_sh[1], '0, s_se[0], s_se[1],
                                          1'b0, ERR_OK, 1'b1);
                                n_fill = '0;
                            end else begin
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        PT_LINE_LOOP, PT_LINE_STRIP: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            if (r_fill == '0) begin
                                // keep the first vertex for the closing line
                                n_sh[2] = s_sh[0];
                                n_se[2] = s_se[0];
                                n_fill  = FILL_W'(1);
                            end else begin
                                has1 = 1'b1;
                                res1 = mk(PK_LINE, s_sh[0], s_sh[1], '0, s_se[0], s_se[1],
                                          1'b0, ERR_OK, 1'b1);
                                n_sh[0] = s_sh[1];
                                n_se[0] = s_se[1];
                                n_fill  = FILL_W'(1);
                            end
                        end
                        PT_TRIS: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            if (r_fill == FILL_W'(2)) begin
                                has1 = 1'b1;
                                res1 = mk(PK_TRI, s_sh[0], s_sh[1], s_sh[2], s_se[0],
                                          s_se[1], s_se[2], ERR_OK, 1'b1);
                                n_fill = '0;
                            end else begin
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        PT_TRI_STRIP: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            n_fill = (r_fill == FILL_W'(2)) ? '0 : r_fill + FILL_W'(1);
                            if (three_nx) begin
                                has1 = 1'b1;
                                // odd count keeps ring order, even count reverses it
                                if (!r_par) begin
                                    res1 = mk(PK_TRI, s_sh[0], s_sh[1], s_sh[2], s_se[0],
                                              s_se[1], s_se[2], ERR_OK, 1'b1);
                                end else begin
                                    res1 = mk(PK_TRI, s_sh[2], s_sh[1], s_sh[0], s_se[2],
                                              s_se[1], s_se[0], ERR_OK, 1'b1);
                                end
                            end
                        end
                        PT_TRI_FAN: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            if (r_fill == FILL_W'(2)) begin
                                has1 = 1'b1;
                                res1 = mk(PK_TRI, s_sh[0], s_sh[1], s_sh[2], s_se[0],
                                          s_se[1], s_se[2], ERR_OK, 1'b1);
                                n_sh[1] = s_sh[2];
                                n_se[1] = s_se[2];
                            end else begin
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        PT_QUADS: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            if (r_fill == FILL_W'(3)) begin
                                has1 = 1'b1;
                                two  = 1'b1;
                                // hide the inner diagonal on both halves
                                res1 = mk(PK_TRI, s_sh[0], s_sh[1], s_sh[2], s_se[0],
                                          s_se[1], 1'b0, ERR_OK, 1'b0);
                                res2 = mk(PK_TRI, s_sh[0], s_sh[2], s_sh[3], 1'b0,
                                          s_se[2], s_se[3], ERR_OK, 1'b1);
                                n_fill = '0;
                            end else begin
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        PT_QUAD_STRIP: begin
                            n_sh = s_sh;
                            n_se = s_se;
                            if (r_fill == FILL_W'(3)) begin
                                has1 = 1'b1;
                                two  = 1'b1;
                                res1 = mk(PK_TRI, s_sh[0], s_sh[1], s_sh[2], s_se[0],
                                          s_se[1], s_se[2], ERR_OK, 1'b0);
                                res2 = mk(PK_TRI, s_sh[1], s_sh[3], s_sh[2], s_se[1],
                                          s_se[3], s_se[2], ERR_OK, 1'b1);
                                n_sh[0] = s_sh[2];
                                n_se[0] = s_se[2];
                                n_sh[1] = s_sh[3];
                                n_se[1] = s_se[3];
                                n_fill  = FILL_W'(2);
                            end else begin
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        PT_POLYGON: begin
                            if (r_fill < MAX_FILL) begin
                                we = 1'b1;
                                if (r_fill[FILL_W-1:2] == '0) begin
                                    n_sh = s_sh;
                                    n_se = s_se;
                                end
                                n_fill = r_fill + FILL_W'(1);
                            end else begin
                                // drop the vertex past capacity
                                has1 = 1'b1;
                                res1 = mk(PK_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                                          ERR_OVERFLOW, 1'b1);
                            end
                        end
                        default: begin
                            // unknown type: count only
                        end
                    endcase
                end
            end
            FN_END: begin
                if (!r_inside) begin
                    has1 = 1'b1;
                end else begin
                    n_inside = 1'b0;
                    if (r_type == PT_LINE_LOOP) begin
                        if (r_cnt == 2'd3) begin
                            has1 = 1'b1;
                            res1 = mk(PK_LINE, r_sh[0], r_sh[2], '0, r_se[0], r_se[2],
                                      1'b0, ERR_OK, 1'b1);
                        end
                    end else if (r_type == PT_POLYGON) begin
                        walk = (r_fill >= FILL_W'(3));
                    end
                end
            end
            default: begin
                has1 = 1'b1;
            end
        endcase
    end

    assign o_stat.out_free    = out_free;
    assign o_stat.two_results = two;
    assign o_stat.poly_end    = walk;
    assign o_stat.walk_last   = (r_ptr == SLOT_AW'(1));

    // Polygon walk read address: top slot at end, then hold or step down
    always_comb begin
        if (i_ctrl.poly_prime) begin
            raddr = r_ptr;
        end else if (i_ctrl.poly_step) begin
            raddr = r_ptr - SLOT_AW'(1);
        end else if (r_ovalid && !i_out_ready && !i_ctrl.take_in) begin
            raddr = r_ptr;
        end else begin
            raddr = r_fill[SLOT_AW-1:0] - SLOT_AW'(1);
        end
    end

    pa_ram #(
        .WIDTH (HW + 1),
        .DEPTH (SLOT_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.take_in && we),
        .i_waddr (r_fill[SLOT_AW-1:0]),
        .i_wdata ({i_in.edge_in, v_h}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register, pending second result and walk registers
    always_comb begin
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        n_pend   = r_pend;
        n_hi     = r_hi;
        n_ptr    = r_ptr;
        priority if (i_ctrl.take_in) begin
            if (has1) begin
                n_ovalid = 1'b1;
                n_out    = res1;
            end
            n_pend = res2;
            n_ptr  = r_fill[SLOT_AW-1:0] - SLOT_AW'(2);
        end else if (i_ctrl.emit_second) begin
            n_ovalid = 1'b1;
            n_out    = r_pend;
        end else if (i_ctrl.poly_prime) begin
            n_hi = rdata;
        end else if (i_ctrl.poly_step) begin
            n_ovalid = 1'b1;
            n_out    = mk(PK_TRI, r_hi[HW-1:0], r_sh[0], rdata[HW-1:0], r_hi[HW],
                          r_se[0], rdata[HW], ERR_OK, r_ptr == SLOT_AW'(1));
            n_hi     = rdata;
            n_ptr    = r_ptr - SLOT_AW'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_type   <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_par    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctrl.take_in) begin
                r_inside <= n_inside;
                r_type   <= n_type;
                r_fill   <= n_fill;
                r_cnt    <= n_cnt;
                r_par    <= n_par;
            end
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_in) begin
            r_sh <= n_sh;
            r_se <= n_se;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
        r_hi   <= n_hi;
        r_ptr  <= n_ptr;
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
endmodule

// ===== bench/pa_checker.sv =====
`timescale 1ns / 1ps
module pa_checker #(
    parameter int POLY_CAP = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  pa_pkg::t_in  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  pa_pkg::t_out i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    import pa_pkg::*;

    // Shadow copy of the assembler state
    logic [FIELD_HW-1:0] slot_h [SLOT_DEPTH];
    logic                slot_f [SLOT_DEPTH];
    bit                  in_prim;
    logic [3:0]          cur_type;
    int                  fill;
    logic [15:0]         vcount;
    bit                  reached3;

    t_out step_q [$];
    t_out prims_due [$];
    int   fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = prims_due.size();

    function automatic string fmt_prim(input t_out r);
        return $sformatf("kind=%0d a=%h b=%h c=%h flags=%b%b%b err=%0d last=%b",
                         r.prim_kind, r.handle_a, r.handle_b, r.handle_c,
                         r.edge_a, r.edge_b, r.edge_c, r.error, r.last);
    endfunction

    function void emit(input logic [1:0] kind, input logic [15:0] ha, hb, hc,
                       input logic ea, eb, ec, input logic [1:0] err);
        t_out r;
        r.prim_kind = kind;
        r.handle_a  = ha;
        r.handle_b  = hb;
        r.handle_c  = hc;
        r.edge_a    = ea;
        r.edge_b    = eb;
        r.edge_c    = ec;
        r.error     = err;
        r.last      = 1'b0;
        step_q.push_back(r);
    endfunction

    function void flag_sequence();
        emit(PK_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0, ERR_SEQUENCE);
    endfunction

    function void slot_line(input int a, input int b);
        emit(PK_LINE, slot_h[a], slot_h[b], '0, slot_f[a], slot_f[b], 1'b0, ERR_OK);
    endfunction

    function void slot_tri(input int a, input int b, input int c);
        emit(PK_TRI, slot_h[a], slot_h[b], slot_h[c], slot_f[a], slot_f[b], slot_f[c], ERR_OK);
    endfunction

    function void copy_slot(input int dst, input int src);
        slot_h[dst] = slot_h[src];
        slot_f[dst] = slot_f[src];
    endfunction

    function void store_vertex(input logic [15:0] h, input logic f);
        slot_h[fill & (SLOT_DEPTH - 1)] = h;
        slot_f[fill & (SLOT_DEPTH - 1)] = f;
        fill++;
    endfunction

    // Count the vertex, then apply the assembly rule of the open primitive
    function void add_vertex(input logic [15:0] h, input logic f);
        vcount = vcount + 16'd1;
        if (vcount >= 16'd3) reached3 = 1'b1;
        case (cur_type)
            PT_POINTS: begin
                fill = 0;
                store_vertex(h, f);
                emit(PK_POINT, slot_h[0], '0, '0, slot_f[0], 1'b0, 1'b0, ERR_OK);
                fill = 0;
            end
            PT_LINES: begin
                store_vertex(h, f);
                if (fill >= 2) begin
                    slot_line(0, 1);
                    fill = 0;
                end
            end
            PT_LINE_LOOP, PT_LINE_STRIP: begin
                store_vertex(h, f);
                if (fill == 1) begin
                    // keep the first vertex for the closing line
                    copy_slot(2, 0);
                end else if (fill >= 2) begin
                    slot_line(0, 1);
                    copy_slot(0, 1);
                    fill = 1;
                end
            end
            PT_TRIS: begin
                store_vertex(h, f);
                if (fill >= 3) begin
                    slot_tri(0, 1, 2);
                    fill = 0;
                end
            end
            PT_TRI_STRIP: begin
                // ring of three slots; flip order on even counts
                store_vertex(h, f);
                if (reached3) begin
                    if (fill >= 3) fill = 0;
                    if (vcount[0]) slot_tri(0, 1, 2);
                    else slot_tri(2, 1, 0);
                end
            end
            PT_TRI_FAN: begin
                store_vertex(h, f);
                if (fill >= 3) begin
                    slot_tri(0, 1, 2);
                    copy_slot(1, 2);
                    fill = 2;
                end
            end
            PT_QUADS: begin
                // clear the inner diagonal flags
                store_vertex(h, f);
                if (fill >= 4) begin
                    emit(PK_TRI, slot_h[0], slot_h[1], slot_h[2],
                         slot_f[0], slot_f[1], 1'b0, ERR_OK);
                    emit(PK_TRI, slot_h[0], slot_h[2], slot_h[3],
                         1'b0, slot_f[2], slot_f[3], ERR_OK);
                    fill = 0;
                end
            end
            PT_QUAD_STRIP: begin
                store_vertex(h, f);
                if (fill >= 4) begin
                    slot_tri(0, 1, 2);
                    slot_tri(1, 3, 2);
                    copy_slot(0, 2);
                    copy_slot(1, 3);
                    fill = 2;
                end
            end
            PT_POLYGON: begin
                // drop vertices past capacity
                if (fill < POLY_CAP && fill < SLOT_DEPTH) store_vertex(h, f);
                else emit(PK_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0, ERR_OVERFLOW);
            end
            default: ;
        endcase
    endfunction

    function void close_prim();
        if (cur_type == PT_LINE_LOOP) begin
            if (reached3) slot_line(0, 2);
        end else if (cur_type == PT_POLYGON) begin
            // fan the stored polygon from the top slot down
            for (int i = fill - 1; i >= 2; i--) slot_tri(i, 0, i - 1);
        end
        in_prim = 1'b0;
    endfunction

    // Predict the results of one accepted event and queue them
    function void assemble_event(input t_in ev);
        t_out tail;
        step_q.delete();
        case (ev.func)
            FN_BEGIN: begin
                if (in_prim) begin
                    flag_sequence();
                end else begin
                    cur_type = ev.prim_type;
                    in_prim  = 1'b1;
                    fill     = 0;
                    vcount   = '0;
                    reached3 = 1'b0;
                end
            end
            FN_VERTEX: begin
                if (in_prim) add_vertex(ev.vertex_handle, ev.edge_in);
                else flag_sequence();
            end
            FN_END: begin
                if (in_prim) close_prim();
                else flag_sequence();
            end
            default: flag_sequence();
        endcase
        if (step_q.size() > 0) begin
            tail = step_q.pop_back();
            tail.last = 1'b1;
            step_q.push_back(tail);
        end
        foreach (step_q[k]) prims_due.push_back(step_q[k]);
    endfunction

    function void check_prim(input t_out got);
        t_out want;
        if (prims_due.size() == 0) begin
            $display("%0t ns unexpected result: expected none, actual %s",
                     $time, fmt_prim(got));
            fail_count++;
        end else begin
            want = prims_due.pop_front();
            if (got !== want) begin
                $display("%0t ns mismatch: expected %s, actual %s",
                         $time, fmt_prim(want), fmt_prim(got));
                fail_count++;
            end
        end
    endfunction

    initial fail_count = 0;

    // Compare results first: a result never belongs to the event taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_DEPTH; s++) begin
                slot_h[s] = '0;
                slot_f[s] = 1'b0;
            end
            in_prim  = 1'b0;
            cur_type = PT_POINTS;
            fill     = 0;
            vcount   = '0;
            reached3 = 1'b0;
            prims_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_prim(i_out_data);
            if (i_in_valid && i_in_ready) assemble_event(i_in_data);
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import pa_pkg::*;

    localparam int         POLY_CAP     = 64;
    localparam int         IDLE_LIMIT   = 1000;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         ITEM_TOTAL   = 272;
    localparam logic [1:0] FN_ILLEGAL   = 2'd3;
    localparam logic [3:0] PT_RSVD_TOP  = 4'd15;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data   = '0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int sent        = 0;
    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;
    bit open_prim   = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    primitive_assembler #(
        .MAX_POLY_VERTICES(POLY_CAP),
        .HANDLE_BITS      (FIELD_HW)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    pa_checker #(.POLY_CAP(POLY_CAP)) prim_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // End the run when no transaction moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stall the result side a random number of cycles before each transaction
    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // Offer one event after a random gap and hold it until taken
    task send_event(input logic [1:0] fn, input logic [3:0] pt, input logic [15:0] h,
                    input logic f);
        int  gap;
        t_in ev;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        ev.func          = fn;
        ev.prim_type     = pt;
        ev.vertex_handle = h;
        ev.edge_in       = f;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= ev;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (fn == FN_BEGIN) open_prim = 1'b1;
        else if (fn == FN_END) open_prim = 1'b0;
        sent++;
    endtask

    task rand_vertex();
        send_event(FN_VERTEX, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
    endtask

    // Issue a well-formed begin, vertices, end sequence
    task run_prim(input logic [3:0] pt, input int nverts);
        if (open_prim) send_event(FN_END, pt, 16'($urandom_range(0, 65535)), 1'b0);
        send_event(FN_BEGIN, pt, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        repeat (nverts) rand_vertex();
        send_event(FN_END, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
    endtask

    // Hold the sender until every expected result is out, then let the block settle
    task drain_wait();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        int         seq;
        logic [3:0] pt;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: out-of-sequence events, handle extremes, loop closing, quads, reserved type
        send_event(FN_VERTEX, PT_POINTS, 16'h1234, 1'b1);
        send_event(FN_END, PT_POINTS, 16'h0000, 1'b0);
        send_event(FN_ILLEGAL, PT_POLYGON, 16'hFFFF, 1'b1);
        send_event(FN_BEGIN, PT_POINTS, 16'h0000, 1'b0);
        send_event(FN_VERTEX, PT_POINTS, 16'hFFFF, 1'b1);
        send_event(FN_VERTEX, PT_RSVD_TOP, 16'h0000, 1'b0);
        send_event(FN_BEGIN, PT_LINES, 16'hFFFF, 1'b1);
        send_event(FN_END, PT_POINTS, 16'h0000, 1'b0);
        run_prim(PT_LINE_LOOP, 3);
        run_prim(PT_QUADS, 4);
        run_prim(PT_RSVD_TOP, 2);
        drain_wait();

        // Random: mostly well-formed primitives, a few full polygons, some noise
        seq = 0;
        while (sent < ITEM_TOTAL) begin
            seq++;
            pt = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            if (seq == 4) begin
                run_prim(PT_POLYGON, POLY_CAP);
            end else if (seq == 12) begin
                run_prim(PT_POLYGON, POLY_CAP + 2);
                drain_wait();
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                               16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                end
            end else if ($urandom_range(0, 9) == 0) begin
                // break a sequence with a second begin
                if (open_prim) send_event(FN_END, pt, 16'h0000, 1'b0);
                send_event(FN_BEGIN, pt, 16'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 4)) rand_vertex();
                send_event(FN_BEGIN, 4'($urandom_range(0, 15)),
                           16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                send_event(FN_END, pt, 16'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)));
            end else begin
                run_prim(pt, $urandom_range(0, 10));
            end
        end

        drain_wait();
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pa_pkg.sv
rtl/pa_ram.sv
rtl/pa_ctrl.sv
rtl/pa_dp.sv
rtl/primitive_assembler.sv
bench/pa_checker.sv
bench/tb_top.sv
